// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker of the median filter.
// Needs nothing else; each file that asserts includes this header by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TWMF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TWMF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/twmf_pkg.sv =====
// Shared types and constants of the time-window median filter.
// Used by the datapath, the controller and the top level; depends on nothing.
`default_nettype none

package twmf_pkg;

  // Field widths of the channels and the configuration register.
  localparam int W_BITS    = 16;
  localparam int T_BITS    = 32;
  localparam int MED_BITS  = 17;
  localparam int CNT_BITS  = 6;

  // Default store depth and reset value of the window register.
  localparam int                DEPTH_DEF    = 32;
  localparam logic [W_BITS-1:0] WINDOW_RESET = 16'd1000;

  // One stored pulse: its width and its arrival time.
  typedef struct packed {
    logic [W_BITS-1:0] width;
    logic [T_BITS-1:0] stamp;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic scan;
    logic rewind;
    logic merge;
    logic commit;
    logic rd_lo;
    logic rd_hi;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic pass_done;
    logic merge_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/time_window_median_filter.sv =====
// Sliding time-window median filter. Each accepted pulse first drops stored
// pulses older than the configured window, evicts the oldest one if the store
// is still full, is inserted into the width-sorted store, and yields one
// result: twice the median width, the entry count and an overflow flag. When
// the store is full, a pulse needs an extra scan pass before the merge pass.
// The time per pulse is set by the passes over the store through its single
// read port.
// Configuration may be written only while the block is idle.
// Depends on twmf_pkg, twmf_ctrl and twmf_datapath.
`default_nettype none

module time_window_median_filter
  import twmf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wr_en,
  input  wire logic [W_BITS-1:0]   cfg_wr_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [W_BITS-1:0]   pulse_len,
  input  wire logic [T_BITS-1:0]   arrival_time,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [MED_BITS-1:0]      median_doubled,
  output logic [CNT_BITS-1:0]      entry_count,
  output logic                     overflow
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     busy;

  // Input transfers are taken only while the controller is idle.
  assign in_stall = rst || busy;

  twmf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .busy     (busy),
    .stat     (stat),
    .cmd      (cmd)
  );

  twmf_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .pulse_len      (pulse_len),
    .arrival_time   (arrival_time),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .median_doubled (median_doubled),
    .entry_count    (entry_count),
    .overflow       (overflow)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/twmf_datapath.sv =====
// Datapath of the median filter: the ping-pong entry store, the read and write
// pointers, the stale and eviction logic, and the output register. Uses twmf_pkg.
`default_nettype none

module twmf_datapath
  import twmf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dp_cmd_t             cmd,
  output dp_stat_t                 stat,
  input  wire logic [W_BITS-1:0]   pulse_len,
  input  wire logic [T_BITS-1:0]   arrival_time,
  input  wire logic                cfg_wr_en,
  input  wire logic [W_BITS-1:0]   cfg_wr_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [MED_BITS-1:0]      median_doubled,
  output logic [CNT_BITS-1:0]      entry_count,
  output logic                     overflow
);

  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int MEM_DEPTH = 2 << AW;

  // Two banks: one is read while the updated list is written to the other.
  entry_t mem [MEM_DEPTH];
  entry_t rd_data;

  logic              bank;
  logic [CW-1:0]     fill;
  logic [CW-1:0]     rd_idx;
  logic [CW-1:0]     wr_idx;
  logic [CW-1:0]     kept;
  logic [W_BITS-1:0] window;
  logic [W_BITS-1:0] new_w;
  logic [T_BITS-1:0] new_t;
  logic              rd_vld;
  logic [AW-1:0]     rd_pos;
  logic [AW-1:0]     best_pos;
  logic [T_BITS-1:0] best_age;
  logic              inserted;
  logic              carry_v;
  entry_t            carry;
  logic [W_BITS-1:0] med_lo;

  logic              more_rd;
  logic              seq_rd;
  logic              rd_en;
  logic [AW:0]       rd_addr;
  logic [AW:0]       wr_addr;
  logic [T_BITS-1:0] age;
  logic              in_win;
  logic              evict;
  logic              survive;
  logic [CW-1:0]     mid_lo;
  logic [CW-1:0]     mid_hi;
  logic              wr_en;
  entry_t            wr_data;
  entry_t            new_entry;
  logic              set_ins;
  logic              load_carry;
  logic              clr_carry;
  logic [CW+CNT_BITS-1:0] cnt_ext;

  // Sequential read pointer and the age test on the entry just read.
  assign more_rd   = rd_idx < fill;
  assign seq_rd    = (cmd.scan || cmd.merge) && more_rd;
  assign age       = new_t - rd_data.stamp;
  assign in_win    = age <= {{(T_BITS-W_BITS){1'b0}}, window};
  assign evict     = kept == CW'(DEPTH);
  assign survive   = rd_vld && in_win && !(evict && (rd_pos == best_pos));
  assign new_entry = '{width: new_w, stamp: new_t};

  // Median positions in the committed list.
  assign mid_lo  = (fill - CW'(1)) >> 1;
  assign mid_hi  = fill >> 1;
  assign cnt_ext = {{CNT_BITS{1'b0}}, fill};

  // Read address selection.
  always_comb begin
    rd_en = seq_rd || cmd.rd_lo || cmd.rd_hi;
    priority if (cmd.rd_lo) begin
      rd_addr = {bank, mid_lo[AW-1:0]};
    end else if (cmd.rd_hi) begin
      rd_addr = {bank, mid_hi[AW-1:0]};
    end else begin
      rd_addr = {bank, rd_idx[AW-1:0]};
    end
  end

  assign wr_addr = {~bank, wr_idx[AW-1:0]};

  // Merge: copy survivors in order and slot the new pulse in front of the first
  // survivor that is not narrower; a one-entry carry absorbs the extra write.
  always_comb begin
    wr_en      = 1'b0;
    wr_data    = rd_data;
    set_ins    = 1'b0;
    load_carry = 1'b0;
    clr_carry  = 1'b0;
    if (cmd.merge) begin
      if (!inserted) begin
        if (survive && (rd_data.width >= new_w)) begin
          wr_en      = 1'b1;
          wr_data    = new_entry;
          set_ins    = 1'b1;
          load_carry = 1'b1;
        end else if (survive) begin
          wr_en = 1'b1;
        end else if (!more_rd && !rd_vld) begin
          wr_en   = 1'b1;
          wr_data = new_entry;
          set_ins = 1'b1;
        end
      end else if (carry_v) begin
        wr_en   = 1'b1;
        wr_data = carry;
        if (survive) begin
          load_carry = 1'b1;
        end else begin
          clr_carry = 1'b1;
        end
      end else if (survive) begin
        wr_en = 1'b1;
      end
    end
  end

  // Entry store with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Control state of the datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      bank      <= 1'b0;
      fill      <= '0;
      window    <= WINDOW_RESET;
      rd_vld    <= 1'b0;
      inserted  <= 1'b0;
      carry_v   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window <= cfg_wr_data;
      end
      rd_vld <= seq_rd;
      if (cmd.start) begin
        inserted <= 1'b0;
        carry_v  <= 1'b0;
      end else begin
        if (set_ins) begin
          inserted <= 1'b1;
        end
        if (load_carry) begin
          carry_v <= 1'b1;
        end else if (clr_carry) begin
          carry_v <= 1'b0;
        end
      end
      if (cmd.commit) begin
        bank <= ~bank;
        fill <= wr_idx;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Pointers, scan results and payload registers.
  always_ff @(posedge clk) begin
    rd_pos <= rd_idx[AW-1:0];
    if (cmd.start || cmd.rewind) begin
      rd_idx <= '0;
    end else if (seq_rd) begin
      rd_idx <= rd_idx + CW'(1);
    end
    if (cmd.start) begin
      wr_idx <= '0;
    end else if (wr_en) begin
      wr_idx <= wr_idx + CW'(1);
    end
    if (cmd.start) begin
      new_w    <= pulse_len;
      new_t    <= arrival_time;
      kept     <= '0;
      best_pos <= '0;
      best_age <= '0;
    end else if (cmd.scan && rd_vld) begin
      if (in_win) begin
        kept <= kept + CW'(1);
      end
      if (age > best_age) begin
        best_age <= age;
        best_pos <= rd_pos;
      end
    end
    if (load_carry) begin
      carry <= rd_data;
    end
    if (cmd.rd_hi) begin
      med_lo <= rd_data.width;
    end
    if (cmd.load_out) begin
      median_doubled <= {1'b0, med_lo} + {1'b0, rd_data.width};
      entry_count    <= cnt_ext[CNT_BITS-1:0];
      overflow       <= evict;
    end
  end

  // Status back to the controller.
  always_comb begin
    stat.full       = fill == CW'(DEPTH);
    stat.pass_done  = !more_rd && !rd_vld;
    stat.merge_done = !more_rd && !rd_vld && inserted && !carry_v;
    stat.out_free   = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/twmf_ctrl.sv =====
// Controller of the median filter: sequences the scan, merge, median read and
// output load of one pulse. Uses twmf_pkg for the command and status structs.
`default_nettype none

module twmf_ctrl
  import twmf_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          busy,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MERGE,
    S_MED_LO,
    S_MED_HI,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  // Commands and next state.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = stat.full ? S_SCAN : S_MERGE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.pass_done) begin
          cmd.rewind = 1'b1;
          state_next = S_MERGE;
        end
      end
      S_MERGE: begin
        if (stat.merge_done) begin
          cmd.commit = 1'b1;
          state_next = S_MED_LO;
        end else begin
          cmd.merge = 1'b1;
        end
      end
      S_MED_LO: begin
        cmd.rd_lo  = 1'b1;
        state_next = S_MED_HI;
      end
      S_MED_HI: begin
        cmd.rd_hi  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and the registered busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= state_next != S_IDLE;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/twmf_checker.sv =====
// Port-level checker of the median filter, bound to the top level.
// Uses twmf_pkg and the macros in assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module twmf_checker
  import twmf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [MED_BITS-1:0] median_doubled,
  input wire logic [CNT_BITS-1:0] entry_count,
  input wire logic                overflow
);

  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH % (1 << CNT_BITS));

  // A stalled result stays offered.
  `TWMF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid, "result dropped while stalled")

  // A stalled result keeps its payload.
  `TWMF_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(median_doubled) && $stable(entry_count) && $stable(overflow), "stalled result changed")

  // An eviction only happens with the store full again after the insert.
  `TWMF_ASSERT_IMPL(a_ovf_full, clk, rst, out_valid && overflow, entry_count == FULL_CNT, "overflow without a full store")

  // After a transfer in, the block is busy with that pulse.
  `TWMF_ASSERT_NEXT(a_busy_after_in, clk, rst, in_valid && !in_stall, in_stall, "input taken twice in a row")

endmodule

bind time_window_median_filter twmf_checker #(
  .DEPTH (DEPTH)
) u_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .median_doubled (median_doubled),
  .entry_count    (entry_count),
  .overflow       (overflow)
);

`default_nettype wire
